// File: rtl/ssse3_pkg.sv
// ----------------------------------------------------------------------------
// SSSE3 packed ALU package
// Operation codes and shared types for the packed integer unit.
// ----------------------------------------------------------------------------
package ssse3_pkg;

    typedef enum logic [3:0] {
        OP_PSHUFB    = 4'd0,
        OP_PHADDW    = 4'd1,
        OP_PHADDD    = 4'd2,
        OP_PHADDSW   = 4'd3,
        OP_PMADDUBSW = 4'd4,
        OP_PHSUBW    = 4'd5,
        OP_PHSUBD    = 4'd6,
        OP_PHSUBSW   = 4'd7,
        OP_PSIGNB    = 4'd8,
        OP_PSIGNW    = 4'd9,
        OP_PSIGND    = 4'd10,
        OP_PMULHRSW  = 4'd11,
        OP_PABSB     = 4'd12,
        OP_PABSW     = 4'd13,
        OP_PABSD     = 4'd14,
        OP_PALIGNR   = 4'd15
    } t_op;

    typedef struct packed {
        t_op          op;
        logic         wide;
        logic [127:0] a;
        logic [127:0] b;
        logic [7:0]   shift;
    } t_item;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'(SAT_MAX)) begin
            return 16'h7fff;
        end else if (v < 18'(SAT_MIN)) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

// File: rtl/ssse3_datapath.sv
// ----------------------------------------------------------------------------
// SSSE3 datapath
// Combinational evaluation of one registered packed operation.
// ----------------------------------------------------------------------------
module ssse3_datapath (
    input  ssse3_pkg::t_item i_item,
    output logic [127:0]     o_result
);
    import ssse3_pkg::*;

    logic [127:0] a, b, r;
    logic [7:0]   ab [0:15];
    logic [7:0]   bb [0:15];
    logic [7:0]   cat [0:31];
    logic [15:0]  aw [0:7];
    logic [15:0]  bw [0:7];
    logic [31:0]  ad [0:3];
    logic [31:0]  bd [0:3];
    logic [15:0]  x16, y16;
    logic [31:0]  x32, y32;
    logic signed [31:0] prod;
    logic [31:0]  rnd;
    logic [8:0]   pos;
    logic [3:0]   idx;
    logic signed [17:0] mad;

    always_comb begin
        a = i_item.a;
        b = i_item.b;
        if (!i_item.wide) begin
            a[127:64] = '0;
            b[127:64] = '0;
        end
        for (int k = 0; k < 16; k++) begin
            ab[k] = a[8*k +: 8];
            bb[k] = b[8*k +: 8];
        end
        for (int k = 0; k < 8; k++) begin
            aw[k] = a[16*k +: 16];
            bw[k] = b[16*k +: 16];
        end
        for (int k = 0; k < 4; k++) begin
            ad[k] = a[32*k +: 32];
            bd[k] = b[32*k +: 32];
        end
        for (int k = 0; k < 32; k++) begin
            cat[k] = '0;
        end
        for (int k = 0; k < 16; k++) begin
            if (i_item.wide) begin
                cat[k]      = bb[k];
                cat[k + 16] = ab[k];
            end else if (k < 8) begin
                cat[k]     = bb[k];
                cat[k + 8] = ab[k];
            end
        end
        r = '0;
        x16 = '0; y16 = '0; x32 = '0; y32 = '0;
        prod = '0; rnd = '0; pos = '0; idx = '0; mad = '0;
        case (i_item.op)
            OP_PSHUFB: begin
                for (int k = 0; k < 16; k++) begin
                    idx = i_item.wide ? bb[k][3:0] : {1'b0, bb[k][2:0]};
                    r[8*k +: 8] = bb[k][7] ? 8'h00 : ab[idx];
                end
            end
            OP_PHADDW, OP_PHSUBW, OP_PHADDSW, OP_PHSUBSW: begin
                for (int k = 0; k < 8; k++) begin
                    if (i_item.wide) begin
                        x16 = (k < 4) ? aw[(2*k) & 7] : bw[(2*k-8) & 7];
                        y16 = (k < 4) ? aw[(2*k+1) & 7] : bw[(2*k-7) & 7];
                    end else begin
                        x16 = (k < 2) ? aw[(2*k) & 7] : bw[(2*k-4) & 7];
                        y16 = (k < 2) ? aw[(2*k+1) & 7] : bw[(2*k-3) & 7];
                    end
                    if (i_item.op == OP_PHADDW) begin
                        r[16*k +: 16] = x16 + y16;
                    end else if (i_item.op == OP_PHSUBW) begin
                        r[16*k +: 16] = x16 - y16;
                    end else if (i_item.op == OP_PHADDSW) begin
                        r[16*k +: 16] = sat16({{2{x16[15]}}, x16} + {{2{y16[15]}}, y16});
                    end else begin
                        r[16*k +: 16] = sat16({{2{x16[15]}}, x16} - {{2{y16[15]}}, y16});
                    end
                end
            end
            OP_PHADDD, OP_PHSUBD: begin
                for (int k = 0; k < 4; k++) begin
                    if (i_item.wide) begin
                        x32 = (k < 2) ? ad[(2*k) & 3] : bd[(2*k-4) & 3];
                        y32 = (k < 2) ? ad[(2*k+1) & 3] : bd[(2*k-3) & 3];
                    end else begin
                        x32 = (k < 1) ? ad[0] : bd[(2*k-2) & 3];
                        y32 = (k < 1) ? ad[1] : bd[(2*k-1) & 3];
                    end
                    r[32*k +: 32] = (i_item.op == OP_PHADDD) ? x32 + y32 : x32 - y32;
                end
            end
            OP_PMADDUBSW: begin
                for (int k = 0; k < 8; k++) begin
                    mad = 18'($signed({1'b0, ab[2*k]}) * $signed(bb[2*k]))
                        + 18'($signed({1'b0, ab[2*k+1]}) * $signed(bb[2*k+1]));
                    r[16*k +: 16] = sat16(mad);
                end
            end
            OP_PSIGNB: begin
                for (int k = 0; k < 16; k++) begin
                    r[8*k +: 8] = bb[k][7] ? -ab[k] : (bb[k] == '0 ? '0 : ab[k]);
                end
            end
            OP_PSIGNW: begin
                for (int k = 0; k < 8; k++) begin
                    r[16*k +: 16] = bw[k][15] ? -aw[k] : (bw[k] == '0 ? '0 : aw[k]);
                end
            end
            OP_PSIGND: begin
                for (int k = 0; k < 4; k++) begin
                    r[32*k +: 32] = bd[k][31] ? -ad[k] : (bd[k] == '0 ? '0 : ad[k]);
                end
            end
            OP_PMULHRSW: begin
                for (int k = 0; k < 8; k++) begin
                    prod = $signed(aw[k]) * $signed(bw[k]);
                    rnd = 32'(prod) + 32'h80004000;
                    r[16*k +: 16] = rnd[30:15];
                end
            end
            OP_PABSB: begin
                for (int k = 0; k < 16; k++) begin
                    r[8*k +: 8] = bb[k][7] ? -bb[k] : bb[k];
                end
            end
            OP_PABSW: begin
                for (int k = 0; k < 8; k++) begin
                    r[16*k +: 16] = bw[k][15] ? -bw[k] : bw[k];
                end
            end
            OP_PABSD: begin
                for (int k = 0; k < 4; k++) begin
                    r[32*k +: 32] = bd[k][31] ? -bd[k] : bd[k];
                end
            end
            default: begin
                for (int k = 0; k < 16; k++) begin
                    pos = {1'b0, i_item.shift} + 9'(k);
                    r[8*k +: 8] = (pos < 9'd32) ? cat[pos[4:0]] : 8'h00;
                end
            end
        endcase
        if (!i_item.wide) begin
            r[127:64] = '0;
        end
        o_result = r;
    end

endmodule

// File: rtl/ssse3_packed_alu_unit.sv
// ----------------------------------------------------------------------------
// SSSE3 packed ALU unit
// Registered single-pass unit for the sixteen SSSE3 integer operations.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// input    in         i_valid, o_stall, i_command .. i_shift_bytes
// output   out        o_valid, i_stall, o_result_lo, o_result_hi
//
// A transaction is registered at the input, evaluated in one combinational
// pass and registered at the output, one per cycle unless the output stalls.
// The input stage stalls only when both stages are full and the output stalls.
// Reset clears both valid flags synchronously.
module ssse3_packed_alu_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_command,
    input  logic        i_wide_mode,
    input  logic [63:0] i_first_lo,
    input  logic [63:0] i_first_hi,
    input  logic [63:0] i_second_lo,
    input  logic [63:0] i_second_hi,
    input  logic [7:0]  i_shift_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_lo,
    output logic [63:0] o_result_hi
);
    import ssse3_pkg::*;

    t_item        r_item;
    logic         r_in_valid, r_out_valid;
    logic [127:0] r_result, n_result;
    logic         adv_out, adv_in;

    ssse3_datapath u_dp (.i_item(r_item), .o_result(n_result));

    assign adv_out = r_in_valid && (!r_out_valid || !i_stall);
    assign adv_in  = !r_in_valid || adv_out;
    assign o_stall = !adv_in;
    assign o_valid = r_out_valid;
    assign o_result_lo = r_result[63:0];
    assign o_result_hi = r_result[127:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_item <= '{op: t_op'(i_command), wide: i_wide_mode,
                        a: {i_first_hi, i_first_lo}, b: {i_second_hi, i_second_lo},
                        shift: i_shift_bytes};
        end
        if (adv_out) begin
            r_result <= n_result;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_result))
        else $error("Result changed while stalled.");
    a_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_out && !r_item.wide |=> r_result[127:64] == '0)
        else $error("Narrow result has non-zero upper half.");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("Input stalled without cause.");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed SSSE3 ALU testbench
// Drives directed and random transactions through the packed ALU with random
// gaps and output stalls; directed results are checked against listed values, the rest with a behavioural model.
// ----------------------------------------------------------------------------
module tb;
    import ssse3_pkg::*;

    typedef struct {
        t_op         op;
        logic        wide;
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
        logic [7:0]  shift;
        logic        known;
        logic [63:0] r_lo;
        logic [63:0] r_hi;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_command = '0;
    logic        i_wide_mode = 1'b0;
    logic [63:0] i_first_lo = '0;
    logic [63:0] i_first_hi = '0;
    logic [63:0] i_second_lo = '0;
    logic [63:0] i_second_hi = '0;
    logic [7:0]  i_shift_bytes = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_result_lo;
    logic [63:0] o_result_hi;

    logic [127:0] pending_results[$];
    t_row         rows[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycles = 0;
    bit           stim_done = 1'b0;
    bit           hold_off = 1'b0;
    bit           op_seen[16];

    ssse3_packed_alu_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] clamp16(input longint v);
        if (v > SAT_MAX) return 16'h7fff;
        if (v < SAT_MIN) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [127:0] alu_result(input t_row t);
        logic [127:0] a, b, r;
        logic [255:0] cat;
        int           n, w, lanes, half, j, idx;
        longint       x, y, s;
        logic [31:0]  d, m;
        logic [31:0]  u;
        a = {t.a_hi, t.a_lo};
        b = {t.b_hi, t.b_lo};
        r = '0;
        n = t.wide ? 16 : 8;
        case (t.op)
            OP_PSHUFB: begin
                for (int k = 0; k < n; k++) begin
                    idx = b[8*k +: 4] & (n - 1);
                    r[8*k +: 8] = b[8*k+7] ? 8'h00 : a[8*idx +: 8];
                end
            end
            OP_PHADDW, OP_PHADDD, OP_PHADDSW, OP_PHSUBW, OP_PHSUBD, OP_PHSUBSW: begin
                w = (t.op == OP_PHADDD || t.op == OP_PHSUBD) ? 4 : 2;
                lanes = n / w;
                half = lanes / 2;
                for (int k = 0; k < lanes; k++) begin
                    j = (k < half) ? k : k - half;
                    if (w == 2) begin
                        x = (k < half) ? longint'($signed(a[32*j +: 16]))
                                       : longint'($signed(b[32*j +: 16]));
                        y = (k < half) ? longint'($signed(a[32*j+16 +: 16]))
                                       : longint'($signed(b[32*j+16 +: 16]));
                        s = (t.op inside {OP_PHSUBW, OP_PHSUBSW}) ? x - y : x + y;
                        r[16*k +: 16] = (t.op inside {OP_PHADDSW, OP_PHSUBSW})
                                        ? clamp16(s) : s[15:0];
                    end else begin
                        x = (k < half) ? longint'(a[64*j +: 32]) : longint'(b[64*j +: 32]);
                        y = (k < half) ? longint'(a[64*j+32 +: 32])
                                       : longint'(b[64*j+32 +: 32]);
                        s = (t.op == OP_PHSUBD) ? x - y : x + y;
                        r[32*k +: 32] = s[31:0];
                    end
                end
            end
            OP_PMADDUBSW: begin
                for (int k = 0; k < n / 2; k++) begin
                    s = longint'(a[16*k +: 8]) * longint'($signed(b[16*k +: 8]))
                      + longint'(a[16*k+8 +: 8]) * longint'($signed(b[16*k+8 +: 8]));
                    r[16*k +: 16] = clamp16(s);
                end
            end
            OP_PSIGNB, OP_PSIGNW, OP_PSIGND, OP_PABSB, OP_PABSW, OP_PABSD: begin
                case (t.op)
                    OP_PSIGNB, OP_PABSB: w = 1;
                    OP_PSIGNW, OP_PABSW: w = 2;
                    default:             w = 4;
                endcase
                m = (w == 4) ? 32'hffffffff : (32'h1 << (8 * w)) - 1;
                for (int k = 0; k < n / w; k++) begin
                    d = 32'(a[8*w*k +: 32]) & m;
                    u = 32'(b[8*w*k +: 32]) & m;
                    if (t.op inside {OP_PABSB, OP_PABSW, OP_PABSD}) begin
                        d = u[8*w-1] ? (0 - u) & m : u;
                    end else if (u[8*w-1]) begin
                        d = (0 - d) & m;
                    end else if (u == 0) begin
                        d = 0;
                    end
                    for (int q = 0; q < 8 * w; q++) r[8*w*k + q] = d[q];
                end
            end
            OP_PMULHRSW: begin
                for (int k = 0; k < n / 2; k++) begin
                    s = longint'($signed(a[16*k +: 16])) * longint'($signed(b[16*k +: 16]));
                    u = s[31:0] + 32'h80004000;
                    r[16*k +: 16] = u[30:15];
                end
            end
            default: begin
                cat = t.wide ? {a, b} : {128'b0, a[63:0], b[63:0]};
                for (int k = 0; k < n; k++) begin
                    idx = t.shift + k;
                    r[8*k +: 8] = (idx < 2 * n) ? cat[8*idx +: 8] : 8'h00;
                end
            end
        endcase
        if (!t.wide) r[127:64] = '0;
        return r;
    endfunction

    function automatic t_row make_row(input t_op op, input logic wide,
                                      input logic [127:0] a, input logic [127:0] b,
                                      input logic [7:0] shift, input logic known,
                                      input logic [127:0] r);
        t_row t;
        t.op = op; t.wide = wide;
        t.a_lo = a[63:0]; t.a_hi = a[127:64];
        t.b_lo = b[63:0]; t.b_hi = b[127:64];
        t.shift = shift; t.known = known;
        t.r_lo = r[63:0]; t.r_hi = r[127:64];
        return t;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = {4{16'h8000}};
            3: v = {8{8'h80}};
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_row(input t_row t);
        logic [127:0] expected;
        int           gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= t.op;
        i_wide_mode <= t.wide;
        i_first_lo <= t.a_lo;
        i_first_hi <= t.a_hi;
        i_second_lo <= t.b_lo;
        i_second_hi <= t.b_hi;
        i_shift_bytes <= t.shift;
        do @(posedge i_clk); while (o_stall);
        expected = t.known ? {t.r_hi, t.r_lo} : alu_result(t);
        pending_results.push_back(expected);
        op_seen[t.op] = 1'b1;
    endtask

    initial begin
        t_row t;
        rows.push_back(make_row(OP_PABSB, 1'b1, '0, {16{8'h80}}, 8'd0, 1'b1, {16{8'h80}}));
        rows.push_back(make_row(OP_PABSW, 1'b1, '0, {8{16'hffff}}, 8'd0, 1'b1, {8{16'h0001}}));
        rows.push_back(make_row(OP_PABSD, 1'b0, '1, {4{32'h80000000}}, 8'd0, 1'b1,
                                {64'h0, {2{32'h80000000}}}));
        rows.push_back(make_row(OP_PSIGNB, 1'b1, {16{8'h80}}, {16{8'hff}}, 8'd0, 1'b1,
                                {16{8'h80}}));
        rows.push_back(make_row(OP_PSIGNW, 1'b1, '1, '0, 8'd0, 1'b1, '0));
        rows.push_back(make_row(OP_PSIGND, 1'b1, {4{32'd5}}, {4{32'd1}}, 8'd0, 1'b1,
                                {4{32'd5}}));
        rows.push_back(make_row(OP_PMULHRSW, 1'b1, {8{16'h8000}}, {8{16'h8000}}, 8'd0,
                                1'b1, {8{16'h8000}}));
        rows.push_back(make_row(OP_PHADDSW, 1'b1, {8{16'h7fff}}, {8{16'h8000}}, 8'd0,
                                1'b1, {{4{16'h8000}}, {4{16'h7fff}}}));
        rows.push_back(make_row(OP_PHSUBSW, 1'b0, {4{16'h8000, 16'h7fff}}, '0, 8'd0, 1'b1,
                                {64'h0, {2{16'h0000}}, {2{16'h7fff}}}));
        rows.push_back(make_row(OP_PMADDUBSW, 1'b1, '1, {16{8'h7f}}, 8'd0, 1'b1,
                                {8{16'h7fff}}));
        rows.push_back(make_row(OP_PMADDUBSW, 1'b1, '1, {16{8'h80}}, 8'd0, 1'b1,
                                {8{16'h8000}}));
        rows.push_back(make_row(OP_PALIGNR, 1'b1, '1, '1, 8'd32, 1'b1, '0));
        rows.push_back(make_row(OP_PALIGNR, 1'b0, '1, '1, 8'd255, 1'b1, '0));
        rows.push_back(make_row(OP_PALIGNR, 1'b1, {64'h1, 64'h2}, {64'h3, 64'h4}, 8'd16,
                                1'b1, {64'h1, 64'h2}));
        rows.push_back(make_row(OP_PSHUFB, 1'b1, '1, {16{8'h80}}, 8'd0, 1'b1, '0));
        for (int k = 0; k < 16; k++) begin
            rows.push_back(make_row(t_op'(k), k[0], {rand64(), rand64()},
                                    {rand64(), rand64()}, 8'($urandom_range(0, 20)), 1'b0, '0));
        end
        rows.push_back(make_row(OP_PALIGNR, 1'b0, {$urandom, $urandom, $urandom, $urandom},
                                '1, 8'd7, 1'b0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send_row(rows[k]);
        for (int k = 0; k < 400; k++) begin
            t = make_row(t_op'($urandom_range(0, 15)), 1'($urandom), {rand64(), rand64()},
                         {rand64(), rand64()}, 8'($urandom_range(0, 40)), 1'b0, '0);
            if ($urandom_range(0, 19) == 0) t.shift = 8'($urandom);
            if (k == 150) hold_off = 1'b1;
            send_row(t);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (hold_off);
        @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (60) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 40) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 30)) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #1;
        wait (!hold_off);
        while (!hold_off) begin
            @(posedge i_clk);
            if (!hold_off) i_stall <= (results_seen > 20) && ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge i_clk) begin
        logic [127:0] expected;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %h %h", o_result_hi, o_result_lo);
            end else begin
                expected = pending_results.pop_front();
                if (expected[63:0] !== o_result_lo || expected[127:64] !== o_result_hi) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h %h, got %h %h",
                                 expected[127:64], expected[63:0], o_result_hi, o_result_lo);
                end
            end
        end
    end

    initial begin
        int ops_covered;
        ops_covered = 0;
        wait (stim_done && pending_results.size() == 0);
        repeat (10) @(posedge i_clk);
        foreach (op_seen[k]) ops_covered += op_seen[k];
        $display("%0d results checked across %0d operations, both widths,", results_seen,
                 ops_covered);
        $display("with random gaps, output stalls and one long hold-off.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        wait (cycles >= 200000);
        $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/ssse3_pkg.sv
rtl/ssse3_datapath.sv
rtl/ssse3_packed_alu_unit.sv
tb/sv/tb.sv
